/* rtl/bes_pkg.sv */
// Shared types and constants for the bevel edge texture shader.
package bes_pkg;

   // Memory word: shape bit over a signed bevel value
   localparam int BEV_W  = 4;
   localparam int LVL_W  = 3;
   localparam int WORD_W = BEV_W + 1;

   // Register indexes of the configuration port
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;

   // Item kinds
   localparam logic KIND_MASK    = 1'b0;
   localparam logic KIND_TEXTURE = 1'b1;

   // Colour channel codes for the shade unit
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // Neighbour visit order during bevel building
   localparam logic [2:0] NB_CENTRE    = 3'd0;
   localparam logic [2:0] NB_LEFT      = 3'd1;
   localparam logic [2:0] NB_UP        = 3'd2;
   localparam logic [2:0] NB_UPLEFT    = 3'd3;
   localparam logic [2:0] NB_RIGHT     = 3'd4;
   localparam logic [2:0] NB_DOWN      = 3'd5;
   localparam logic [2:0] NB_DOWNRIGHT = 3'd6;

   typedef struct packed {
      logic             valid;
      logic [1:0]       ch;
      logic [7:0]       c;
      logic [BEV_W-1:0] v;
   } shd_req_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] ch;
      logic [7:0] value;
   } shd_rsp_type;

endpackage

/* rtl/bes_if.sv */
// Channel interfaces: texture/mask requests, shaded responses, register writes.
interface bes_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic       is_background;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic       last_in;
   modport source (output valid, kind, is_background, red_in, green_in, blue_in, last_in,
                   input ready);
   modport sink   (input valid, kind, is_background, red_in, green_in, blue_in, last_in,
                   output ready);
endinterface

interface bes_rsp_if;
   logic       valid;
   logic       ready;
   logic       background_out;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       last_out;
   modport source (output valid, background_out, red_out, green_out, blue_out, last_out,
                   input ready);
   modport sink   (input valid, background_out, red_out, green_out, blue_out, last_out,
                   output ready);
endinterface

interface bes_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/bes_pix_ram.sv */
// Pixel store: one write port, one registered read port.
module bes_pix_ram #(
   parameter int AW = 16,
   parameter int DW = 5
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [(1 << AW)];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* rtl/bes_shade_unit.sv */
// Two-stage shared channel shader: c +/- span*|v| / (THICKNESS+2).
module bes_shade_unit #(
   parameter int THICKNESS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bes_pkg::shd_req_type req,
   output bes_pkg::shd_rsp_type rsp
);

   localparam int DIVISOR = THICKNESS + 2;
   localparam int NW      = 11;
   localparam int KS      = NW + 4;
   localparam int RECIP   = ((1 << KS) + DIVISOR - 1) / DIVISOR;
   localparam logic [KS-1:0] RECIP_C = KS'(RECIP);

   logic          s1_valid_ff, s2_valid_ff;
   logic [1:0]    s1_ch_ff, s2_ch_ff;
   logic [7:0]    s1_c_ff, s2_c_ff;
   logic          s1_neg_ff, s2_neg_ff;
   logic [NW-1:0] s1_n_ff;
   logic [9:0]    s2_q_ff;

   logic [7:0]          span;
   logic [3:0]          vmag;
   logic [NW-1:0]       s1_n_in;
   logic [NW+KS-1:0]    prod;
   logic [9:0]          s2_q_in;
   logic [9:0]          sum;

   // stage 1: distance to the rail times bevel magnitude
   always_comb begin
      span    = req.v[bes_pkg::BEV_W-1] ? req.c : 8'd255 - req.c;
      vmag    = req.v[bes_pkg::BEV_W-1] ? 4'(-req.v) : req.v;
      s1_n_in = NW'(span) * NW'(vmag[2:0]);
   end

   // stage 2: divide by reciprocal multiply, exact for 11-bit numerators
   always_comb begin
      prod    = (NW+KS)'(s1_n_ff) * (NW+KS)'(RECIP_C);
      s2_q_in = 10'(prod >> KS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_ch_ff  <= req.ch;
      s1_c_ff   <= req.c;
      s1_neg_ff <= req.v[bes_pkg::BEV_W-1];
      s1_n_ff   <= s1_n_in;
      s2_ch_ff  <= s1_ch_ff;
      s2_c_ff   <= s1_c_ff;
      s2_neg_ff <= s1_neg_ff;
      s2_q_ff   <= s2_q_in;
   end

   // final add or subtract
   always_comb begin
      sum       = s2_neg_ff ? {2'b00, s2_c_ff} - s2_q_ff : {2'b00, s2_c_ff} + s2_q_ff;
      rsp.valid = s2_valid_ff;
      rsp.ch    = s2_ch_ff;
      rsp.value = sum[7:0];
   end

endmodule

/* rtl/bevel_edge_texture_shader.sv */
// Top level of the bevel edge texture shader.
// Mask pixels load one per cycle in raster order while the block is ready; when the
// mask is done (last_in or width*height pixels, with a zero fill for missing pixels at
// one per cycle) the block builds the bevel map with a sequencer that walks the pixel
// store through its single read port: the first pass reads each background pixel once
// and the centre plus six neighbours of each shape pixel, and each of up to
// THICKNESS-1 further passes reads each interior pixel alone or with its neighbours.
// Texture pixels then pass through or are shaded, the three channels going one after
// another through a shared two-stage shade unit. The block is not ready while filling,
// building or shading, nor in the cycle after a register write.
module bevel_edge_texture_shader #(
   parameter int MAX_SIDE  = 256,
   parameter int THICKNESS = 4
) (
   input logic        clock,
   input logic        reset,
   bes_req_if.sink    req_chan,
   bes_rsp_if.source  rsp_chan,
   bes_csr_if.sink    csr_chan
);

   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int TW = AW + 1;
   localparam int BW = bes_pkg::BEV_W;
   localparam int LW = bes_pkg::LVL_W;

   typedef enum logic [8:0] {
      ST_LOAD   = 9'b000000001,
      ST_FILL   = 9'b000000010,
      ST_B_RD   = 9'b000000100,
      ST_B_EV   = 9'b000001000,
      ST_SHADE  = 9'b000010000,
      ST_S_EV   = 9'b000100000,
      ST_S_MUL  = 9'b001000000,
      ST_S_WAIT = 9'b010000000,
      ST_S_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [SW-1:0] x_ff, x_in, y_ff, y_in;
   logic [SW-1:0] w_ff, w_in, h_ff, h_in;
   logic [TW-1:0] total_ff;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [2:0]    nb_ff, nb_in;
   logic          lt_ff, lt_in, dk_ff, dk_in;
   logic [1:0]    ch_ff, ch_in;
   logic          pend_ff;
   logic [7:0]    red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic          last_ff, last_in;
   logic [BW-1:0] v_ff, v_in;
   logic          res_bg_ff, res_bg_in;
   logic [7:0]    res_r_ff, res_r_in, res_g_ff, res_g_in, res_b_ff, res_b_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_bg_ff, rsp_bg_in, rsp_last_ff, rsp_last_in;
   logic [7:0]    rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in, rsp_b_ff, rsp_b_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr, nb_off, wa;
   logic [bes_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

   bes_pkg::shd_req_type shd_req;
   bes_pkg::shd_rsp_type shd_rsp;

   logic          req_fire, csr_fire, csr_hit;
   logic [31:0]   csr_val32;
   logic [SW-1:0] side_new;
   logic          first_pass, row_end, pass_end, adv, oob, hit, lt_new, dk_new;
   logic [SW-1:0] x_end, y_end;
   logic [BW-1:0] lvl4, lvl_p1, bev_wr;
   logic [AW-1:0] lp;
   logic [TW-1:0] np_ext, pos_next;

   // Pixel store and shade unit
   bes_pix_ram #(.AW(AW), .DW(bes_pkg::WORD_W)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   bes_shade_unit #(.THICKNESS(THICKNESS)) u_shade (
      .clock (clock),
      .reset (reset),
      .req   (shd_req),
      .rsp   (shd_rsp)
   );

   // Handshakes
   assign req_chan.ready = ((state_ff == ST_LOAD) || (state_ff == ST_SHADE)) && !pend_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;
   assign csr_hit        = csr_fire && ((csr_chan.index == bes_pkg::REG_WIDTH) ||
                                        (csr_chan.index == bes_pkg::REG_HEIGHT));

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.background_out = rsp_bg_ff;
   assign rsp_chan.red_out        = rsp_r_ff;
   assign rsp_chan.green_out      = rsp_g_ff;
   assign rsp_chan.blue_out       = rsp_b_ff;
   assign rsp_chan.last_out       = rsp_last_ff;

   // Side clamp for register writes
   always_comb begin
      csr_val32 = 32'(csr_chan.data);
      if (csr_val32 == 32'd0) begin
         side_new = SW'(1);
      end else if (csr_val32 > 32'(MAX_SIDE)) begin
         side_new = SW'(MAX_SIDE);
      end else begin
         side_new = SW'(csr_val32);
      end
      w_in = w_ff;
      h_in = h_ff;
      if (csr_fire && (csr_chan.index == bes_pkg::REG_WIDTH)) begin
         w_in = side_new;
      end
      if (csr_fire && (csr_chan.index == bes_pkg::REG_HEIGHT)) begin
         h_in = side_new;
      end
   end

   // Shared address adder: position plus neighbour offset
   always_comb begin
      wa = AW'(w_ff);
      unique case (nb_ff)
         bes_pkg::NB_LEFT:      nb_off = '1;
         bes_pkg::NB_UP:        nb_off = -wa;
         bes_pkg::NB_UPLEFT:    nb_off = -wa - AW'(1);
         bes_pkg::NB_RIGHT:     nb_off = AW'(1);
         bes_pkg::NB_DOWN:      nb_off = wa;
         bes_pkg::NB_DOWNRIGHT: nb_off = wa + AW'(1);
         default:               nb_off = '0;
      endcase
      mem_raddr = pos_ff + nb_off;
   end

   // Pass geometry and neighbour tests
   always_comb begin
      first_pass = (lvl_ff == LW'(THICKNESS));
      x_end      = first_pass ? w_ff - SW'(1) : w_ff - SW'(2);
      y_end      = first_pass ? h_ff - SW'(1) : h_ff - SW'(2);
      row_end    = (x_ff == x_end);
      pass_end   = row_end && (y_ff == y_end);
      lvl4       = {1'b0, lvl_ff};
      lvl_p1     = lvl4 + BW'(1);
      unique case (nb_ff)
         bes_pkg::NB_LEFT:      oob = (x_ff == '0);
         bes_pkg::NB_UP:        oob = (y_ff == '0);
         bes_pkg::NB_UPLEFT:    oob = (x_ff == '0) || (y_ff == '0);
         bes_pkg::NB_RIGHT:     oob = (x_ff == w_ff - SW'(1));
         bes_pkg::NB_DOWN:      oob = (y_ff == h_ff - SW'(1));
         bes_pkg::NB_DOWNRIGHT: oob = (x_ff == w_ff - SW'(1)) || (y_ff == h_ff - SW'(1));
         default:               oob = 1'b0;
      endcase
      if (first_pass) begin
         hit = oob || !mem_rdata[BW];
      end else if (nb_ff <= bes_pkg::NB_UPLEFT) begin
         hit = (mem_rdata[BW-1:0] == lvl_p1);
      end else begin
         hit = (mem_rdata[BW-1:0] == -lvl_p1);
      end
      lt_new = lt_ff || ((nb_ff <= bes_pkg::NB_UPLEFT) && hit);
      dk_new = dk_ff || ((nb_ff > bes_pkg::NB_UPLEFT) && hit);
      if (lt_new && !dk_new) begin
         bev_wr = lvl4;
      end else if (!lt_new && dk_new) begin
         bev_wr = -lvl4;
      end else begin
         bev_wr = '0;
      end
      lp       = (state_ff == ST_SHADE) ? '0 : pos_ff;
      np_ext   = {1'b0, lp} + TW'(1);
      pos_next = {1'b0, pos_ff} + TW'(1);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      lvl_in       = lvl_ff;
      nb_in        = nb_ff;
      lt_in        = lt_ff;
      dk_in        = dk_ff;
      ch_in        = ch_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      last_in      = last_ff;
      v_in         = v_ff;
      res_bg_in    = res_bg_ff;
      res_r_in     = res_r_ff;
      res_g_in     = res_g_ff;
      res_b_in     = res_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_bg_in    = rsp_bg_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = '0;
      shd_req      = '0;
      adv          = 1'b0;

      // shaded channels land as the unit returns them
      if (shd_rsp.valid) begin
         unique case (shd_rsp.ch)
            bes_pkg::CH_RED:   res_r_in = shd_rsp.value;
            bes_pkg::CH_GREEN: res_g_in = shd_rsp.value;
            default:           res_b_in = shd_rsp.value;
         endcase
      end

      unique case (state_ff)
         ST_LOAD, ST_SHADE: begin
            if (req_fire && (req_chan.kind == bes_pkg::KIND_MASK)) begin
               mem_we    = 1'b1;
               mem_waddr = lp;
               mem_wdata = {!req_chan.is_background, {BW{1'b0}}};
               if (req_chan.last_in || (np_ext >= total_ff)) begin
                  if (np_ext < total_ff) begin
                     state_in = ST_FILL;
                     pos_in   = AW'(np_ext);
                  end else begin
                     state_in = ST_B_RD;
                     pos_in   = '0;
                     x_in     = '0;
                     y_in     = '0;
                     lvl_in   = LW'(THICKNESS);
                     nb_in    = bes_pkg::NB_CENTRE;
                  end
               end else begin
                  state_in = ST_LOAD;
                  pos_in   = AW'(np_ext);
               end
            end else if (req_fire && (state_ff == ST_SHADE)) begin
               red_in   = req_chan.red_in;
               green_in = req_chan.green_in;
               blue_in  = req_chan.blue_in;
               last_in  = req_chan.last_in;
               state_in = ST_S_EV;
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (pos_next >= total_ff) begin
               state_in = ST_B_RD;
               pos_in   = '0;
               x_in     = '0;
               y_in     = '0;
               lvl_in   = LW'(THICKNESS);
               nb_in    = bes_pkg::NB_CENTRE;
            end else begin
               pos_in = AW'(pos_next);
            end
         end
         ST_B_RD: begin
            state_in = ST_B_EV;
         end
         ST_B_EV: begin
            if (nb_ff == bes_pkg::NB_CENTRE) begin
               if (!mem_rdata[BW]) begin
                  // background: first pass clears its bevel, later passes skip it
                  mem_we = first_pass;
                  adv    = 1'b1;
               end else if (!first_pass && (mem_rdata[BW-1:0] != '0)) begin
                  adv = 1'b1;
               end else begin
                  nb_in    = bes_pkg::NB_LEFT;
                  lt_in    = 1'b0;
                  dk_in    = 1'b0;
                  state_in = ST_B_RD;
               end
            end else if (nb_ff == bes_pkg::NB_DOWNRIGHT) begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, bev_wr};
               adv       = 1'b1;
            end else begin
               nb_in    = nb_ff + 3'd1;
               lt_in    = lt_new;
               dk_in    = dk_new;
               state_in = ST_B_RD;
            end
         end
         ST_S_EV: begin
            v_in = mem_rdata[BW-1:0];
            if (!mem_rdata[BW]) begin
               res_bg_in = 1'b1;
               res_r_in  = '0;
               res_g_in  = '0;
               res_b_in  = '0;
               state_in  = ST_S_DONE;
            end else if ((mem_rdata[BW-1:0] == '0) ||
                         ((red_ff == 8'd255) && (green_ff == 8'd0) && (blue_ff == 8'd255))) begin
               res_bg_in = 1'b0;
               res_r_in  = red_ff;
               res_g_in  = green_ff;
               res_b_in  = blue_ff;
               state_in  = ST_S_DONE;
            end else begin
               res_bg_in = 1'b0;
               ch_in     = bes_pkg::CH_RED;
               state_in  = ST_S_MUL;
            end
         end
         ST_S_MUL: begin
            shd_req.valid = 1'b1;
            shd_req.ch    = ch_ff;
            shd_req.v     = v_ff;
            unique case (ch_ff)
               bes_pkg::CH_RED:   shd_req.c = red_ff;
               bes_pkg::CH_GREEN: shd_req.c = green_ff;
               default:           shd_req.c = blue_ff;
            endcase
            ch_in = ch_ff + 2'd1;
            if (ch_ff == bes_pkg::CH_BLUE) begin
               state_in = ST_S_WAIT;
            end
         end
         ST_S_WAIT: begin
            if (shd_rsp.valid && (shd_rsp.ch == bes_pkg::CH_BLUE)) begin
               state_in = ST_S_DONE;
            end
         end
         ST_S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bg_in    = res_bg_ff;
               rsp_r_in     = res_r_ff;
               rsp_g_in     = res_g_ff;
               rsp_b_in     = res_b_ff;
               rsp_last_in  = last_ff || (pos_next >= total_ff);
               if (last_ff || (pos_next >= total_ff)) begin
                  state_in = ST_LOAD;
                  pos_in   = '0;
               end else begin
                  state_in = ST_SHADE;
                  pos_in   = AW'(pos_next);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // step to the next pixel of the bevel walk
      if (adv) begin
         nb_in    = bes_pkg::NB_CENTRE;
         state_in = ST_B_RD;
         if (pass_end) begin
            if ((lvl_ff == LW'(1)) || (w_ff < SW'(3)) || (h_ff < SW'(3))) begin
               state_in = ST_SHADE;
               pos_in   = '0;
            end else begin
               lvl_in = lvl_ff - LW'(1);
               x_in   = SW'(1);
               y_in   = SW'(1);
               pos_in = wa + AW'(1);
            end
         end else if (row_end) begin
            x_in   = first_pass ? SW'(0) : SW'(1);
            y_in   = y_ff + SW'(1);
            pos_in = pos_ff + (first_pass ? AW'(1) : AW'(3));
         end else begin
            x_in   = x_ff + SW'(1);
            pos_in = pos_ff + AW'(1);
         end
      end

      // a width or height register write aborts the piece
      if (csr_hit) begin
         state_in = ST_LOAD;
         pos_in   = '0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pos_ff       <= '0;
         nb_ff        <= bes_pkg::NB_CENTRE;
         ch_ff        <= bes_pkg::CH_RED;
         lvl_ff       <= LW'(THICKNESS);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         w_ff         <= SW'(1);
         h_ff         <= SW'(1);
         total_ff     <= TW'(1);
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         nb_ff        <= nb_in;
         ch_ff        <= ch_in;
         lvl_ff       <= lvl_in;
         pend_ff      <= csr_fire;
         rsp_valid_ff <= rsp_valid_in;
         w_ff         <= w_in;
         h_ff         <= h_in;
         total_ff     <= TW'(w_ff * h_ff);
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      lt_ff       <= lt_in;
      dk_ff       <= dk_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      last_ff     <= last_in;
      v_ff        <= v_in;
      res_bg_ff   <= res_bg_in;
      res_r_ff    <= res_r_in;
      res_g_ff    <= res_g_in;
      res_b_ff    <= res_b_in;
      rsp_bg_ff   <= rsp_bg_in;
      rsp_last_ff <= rsp_last_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_g_ff    <= rsp_g_in;
      rsp_b_ff    <= rsp_b_in;
   end

   // Checks
   a_no_write_while_shading: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_S_EV) || (state_ff == ST_S_MUL) || (state_ff == ST_S_WAIT) ||
       (state_ff == ST_S_DONE)) |-> !mem_we)
      else $error("pixel store written while shading");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_S_DONE))
      else $error("response raised outside the result state");

   a_shade_pos_in_piece: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHADE) |-> ({1'b0, pos_ff} < total_ff))
      else $error("shading position beyond the piece");

endmodule

/* verif/bes_tb_if.sv */
// Package of testbench constants for the bevel shader bench.
package bes_tb_pkg;
   localparam int TB_MAX_SIDE  = 256;
   localparam int TB_THICKNESS = 4;
endpackage

/* verif/tb_bevel_edge_texture_shader.sv */
// Self-checking testbench for the bevel edge texture shader: mask/texture pieces, random stalls.
module tb_bevel_edge_texture_shader;

   localparam int CELLS     = bes_tb_pkg::TB_MAX_SIDE * bes_tb_pkg::TB_MAX_SIDE;
   localparam int WD_LIMIT  = 400000;

   typedef struct packed {
      logic       kind;
      logic       is_bg;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic       last;
   } pixel_type;

   typedef struct packed {
      logic       bg;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic       last;
   } shaded_type;

   logic clock;
   logic reset;

   bes_req_if req_chan ();
   bes_rsp_if rsp_chan ();
   bes_csr_if csr_chan ();

   bevel_edge_texture_shader #(.MAX_SIDE(bes_tb_pkg::TB_MAX_SIDE),
                               .THICKNESS(bes_tb_pkg::TB_THICKNESS)) uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   // Predictor state
   bit        mask_mem [CELLS];
   int        bevel_mem [CELLS];
   int        pos;
   bit        shading;
   int        pw, ph;

   pixel_type  pending_px [$];
   shaded_type expected_px [$];
   int        n_queued;
   int        mismatches;
   int        watchdog;
   bit        timed_out;
   bit        stim_done;
   bit        no_idle;
   bit        req_taken;
   int        req_gap, rsp_gap;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_item(pixel_type p);
      pending_px.insert(pending_px.size(), p);
      n_queued++;
   endfunction

   function automatic bit is_bg_at(int x, int y);
      if (x < 0 || y < 0 || x >= pw || y >= ph) return 1'b1;
      return !mask_mem[y * pw + x];
   endfunction

   function automatic void build_bevel_map();
      bit lt, dk;
      int i;
      for (int k = 0; k < pw * ph; k++) bevel_mem[k] = 0;
      for (int y = 0; y < ph; y++)
         for (int x = 0; x < pw; x++) begin
            if (is_bg_at(x, y)) continue;
            lt = is_bg_at(x-1, y) || is_bg_at(x, y-1) || is_bg_at(x-1, y-1);
            dk = is_bg_at(x+1, y) || is_bg_at(x, y+1) || is_bg_at(x+1, y+1);
            if (lt && !dk) bevel_mem[y*pw+x] = bes_tb_pkg::TB_THICKNESS;
            if (!lt && dk) bevel_mem[y*pw+x] = -bes_tb_pkg::TB_THICKNESS;
         end
      for (int s = bes_tb_pkg::TB_THICKNESS - 1; s > 0; s--)
         for (int y = 1; y < ph - 1; y++)
            for (int x = 1; x < pw - 1; x++) begin
               i = y * pw + x;
               if (bevel_mem[i] != 0 || is_bg_at(x, y)) continue;
               lt = bevel_mem[i-1] == s+1 || bevel_mem[i-pw] == s+1 ||
                    bevel_mem[i-pw-1] == s+1;
               dk = bevel_mem[i+1] == -s-1 || bevel_mem[i+pw] == -s-1 ||
                    bevel_mem[i+pw+1] == -s-1;
               if (lt && !dk) bevel_mem[i] = s;
               if (!lt && dk) bevel_mem[i] = -s;
            end
   endfunction

   function automatic logic [7:0] shade_channel(logic [7:0] c, int v);
      int base;
      base = c;
      if (v > 0) return 8'(base + (255 - base) * v / (bes_tb_pkg::TB_THICKNESS + 2));
      return 8'(base - base * (-v) / (bes_tb_pkg::TB_THICKNESS + 2));
   endfunction

   // Works out the result (if any) of one accepted pixel
   function automatic void predict_pixel(pixel_type p);
      int total, v;
      bit fin;
      shaded_type o;
      total = pw * ph;
      if (p.kind == bes_pkg::KIND_MASK) begin
         if (shading) begin
            shading = 1'b0;
            pos = 0;
         end
         if (pos < total) begin
            mask_mem[pos] = !p.is_bg;
            pos++;
         end
         if (p.last || pos >= total) begin
            while (pos < total) begin
               mask_mem[pos] = 1'b0;
               pos++;
            end
            build_bevel_map();
            shading = 1'b1;
            pos = 0;
         end
      end else begin
         if (!shading || pos >= total) return;
         fin = p.last || (pos + 1 >= total);
         o = '0;
         if (!mask_mem[pos]) o.bg = 1'b1;
         else begin
            v = bevel_mem[pos];
            if (v == 0 || (p.r == 8'd255 && p.g == 8'd0 && p.b == 8'd255)) begin
               o.r = p.r; o.g = p.g; o.b = p.b;
            end else begin
               o.r = shade_channel(p.r, v);
               o.g = shade_channel(p.g, v);
               o.b = shade_channel(p.b, v);
            end
         end
         o.last = fin;
         pos++;
         if (fin) begin
            shading = 1'b0;
            pos = 0;
         end
         expected_px.insert(expected_px.size(), o);
      end
   endfunction

   function automatic int clamp_side(logic [8:0] v);
      if (v == 0) return 1;
      if (v > bes_tb_pkg::TB_MAX_SIDE) return bes_tb_pkg::TB_MAX_SIDE;
      return v;
   endfunction

   // Driver: request channel
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_chan.valid || req_taken) begin
         // previous transaction accepted or none pending
         if (req_gap > 0) begin
            req_chan.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_px.size() > 0) begin
            if (!no_idle && $urandom_range(0, 15) == 0) begin
               req_chan.valid <= 1'b0;
               req_gap <= $urandom_range(1, 14);
            end else begin
               {req_chan.kind, req_chan.is_background, req_chan.red_in,
                req_chan.green_in, req_chan.blue_in, req_chan.last_in}
                  <= pending_px.pop_front();
               req_chan.valid <= 1'b1;
            end
         end else req_chan.valid <= 1'b0;
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= $urandom_range(1, 14);
      end else rsp_chan.ready <= 1'b1;
   end

   // Monitor: predicts on accepted pixels, checks accepted results
   always @(posedge clock) begin
      shaded_type got, want;
      bit moved;
      moved = 1'b0;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predict_pixel({req_chan.kind, req_chan.is_background, req_chan.red_in,
                           req_chan.green_in, req_chan.blue_in, req_chan.last_in});
            moved = 1'b1;
         end
         if (csr_chan.valid && csr_chan.ready) moved = 1'b1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            got = {rsp_chan.background_out, rsp_chan.red_out, rsp_chan.green_out,
                   rsp_chan.blue_out, rsp_chan.last_out};
            if (expected_px.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_px.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: bg %b/%b r %h/%h g %h/%h b %h/%h last %b/%b",
                              want.bg, got.bg, want.r, got.r, want.g, got.g,
                              want.b, got.b, want.last, got.last);
               end
            end
         end
         watchdog <= moved ? 0 : watchdog + 1;
         if (watchdog >= WD_LIMIT) timed_out <= 1'b1;
      end
   end

   // Register write, block idle; model updates at the accepting edge
   task automatic write_reg(logic [1:0] idx, logic [8:0] val);
      @(negedge clock);
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == bes_pkg::REG_WIDTH) pw = clamp_side(val);
      else ph = clamp_side(val);
      shading = 1'b0;
      pos = 0;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while ((pending_px.size() > 0 || req_chan.valid || expected_px.size() > 0)
             && !timed_out) @(posedge clock);
      // building pass after a mask with no result can be long
      repeat (20000) @(posedge clock);
   endtask

   function automatic pixel_type rand_pixel(logic k, logic l);
      pixel_type p;
      p.kind = k;
      p.is_bg = 1'($urandom_range(0, 1));
      p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom);
      if ($urandom_range(0, 9) == 0) {p.r, p.g, p.b} = 24'hFF00FF;
      p.last = l;
      return p;
   endfunction

   // Queue a full piece: mask of a blob shape then a texture pass
   task automatic queue_piece(int w, int h, bit short_mask, bit short_tex);
      int n, cut;
      int cx, cy, rx, ry;
      pixel_type p;
      n = w * h;
      cx = $urandom_range(0, w - 1); cy = $urandom_range(0, h - 1);
      rx = $urandom_range(1, w); ry = $urandom_range(1, h);
      cut = short_mask ? $urandom_range(1, n) : n;
      for (int i = 0; i < cut; i++) begin
         p = rand_pixel(bes_pkg::KIND_MASK,
                        (i == cut - 1) && (short_mask || $urandom_range(0, 1)));
         p.is_bg = ($urandom_range(0, 19) == 0) ? ~p.is_bg :
                   !((i % w - cx) * (i % w - cx) * ry * ry +
                     (i / w - cy) * (i / w - cy) * rx * rx <= rx * rx * ry * ry);
         queue_item(p);
      end
      cut = short_tex ? $urandom_range(1, n) : n;
      for (int i = 0; i < cut; i++)
         queue_item(rand_pixel(bes_pkg::KIND_TEXTURE, short_tex && i == cut - 1));
   endtask

   initial begin
      int w, h;
      reset = 1'b1;
      req_chan.valid = 1'b0; req_chan.kind = 1'b0; req_chan.is_background = 1'b0;
      req_chan.red_in = '0; req_chan.green_in = '0; req_chan.blue_in = '0;
      req_chan.last_in = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0; csr_chan.index = bes_pkg::REG_WIDTH; csr_chan.data = '0;
      pw = 1; ph = 1; pos = 0; shading = 1'b0;
      mismatches = 0; watchdog = 0; timed_out = 1'b0; no_idle = 1'b0;
      stim_done = 1'b0; n_queued = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: 1x1 piece, texture while loading, extremes of colour
      queue_item({bes_pkg::KIND_TEXTURE, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1});
      queue_item({bes_pkg::KIND_MASK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1});
      queue_item({bes_pkg::KIND_TEXTURE, 1'b1, 8'hFF, 8'h00, 8'hFF, 1'b0});
      queue_item({bes_pkg::KIND_MASK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0});
      queue_item({bes_pkg::KIND_TEXTURE, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b1});
      wait_drain();
      // 9x9 solid square: both bevel signs, inner passes
      write_reg(bes_pkg::REG_WIDTH, 9'd9);
      write_reg(bes_pkg::REG_HEIGHT, 9'd9);
      for (int i = 0; i < 81; i++)
         queue_item({bes_pkg::KIND_MASK, 1'b0, 8'hAA, 8'h55, 8'h0F, 1'b0});
      for (int i = 0; i < 81; i++)
         queue_item({bes_pkg::KIND_TEXTURE, 1'b0, 8'(i * 3), 8'hFF - 8'(i), 8'h80, 1'b0});
      queue_piece(9, 9, 1'b0, 1'b1);
      queue_item({bes_pkg::KIND_MASK, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1});
      queue_item({bes_pkg::KIND_TEXTURE, 1'b1, 8'hFF, 8'h00, 8'hFF, 1'b1});
      wait_drain();
      // out-of-range sizes: zero and above maximum
      write_reg(bes_pkg::REG_WIDTH, 9'd0);
      write_reg(bes_pkg::REG_HEIGHT, 9'h1FF);
      queue_piece(1, bes_tb_pkg::TB_MAX_SIDE, 1'b0, 1'b0);
      wait_drain();
      write_reg(bes_pkg::REG_WIDTH, 9'd256);
      write_reg(bes_pkg::REG_HEIGHT, 9'd1);
      queue_piece(bes_tb_pkg::TB_MAX_SIDE, 1, 1'b1, 1'b0);
      wait_drain();

      // Random pieces of small size
      while (n_queued < 1400 && !timed_out) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 12);
         write_reg(bes_pkg::REG_WIDTH, 9'(w));
         write_reg(bes_pkg::REG_HEIGHT, 9'(h));
         repeat ($urandom_range(1, 3)) begin
            queue_piece(w, h, $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0)
               queue_item(rand_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         end
         if (n_queued > 1200) no_idle = 1'b1;
         wait_drain();
      end
      stim_done = 1'b1;
   end

   // End of run
   initial begin
      wait (stim_done || timed_out);
      if (timed_out) $display("tb_bevel_edge_texture_shader failed");
      else if (mismatches == 0 && expected_px.size() == 0)
         $display("tb_bevel_edge_texture_shader passed");
      else
         $display("tb_bevel_edge_texture_shader failed");
      $finish;
   end

endmodule
